@@ sv/pcpd_pkg.sv @@
package pcpd_pkg;

    // One input word after it has been taken off the slave stream.
    typedef struct packed {
        logic        column_start;
        logic        lump_end;
        logic [11:0] column_index;
        logic [7:0]  data_byte;
    } t_item;

    // One result word as it travels to the master stream.
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [11:0] pixel_column;
        logic [11:0] pixel_row;
        logic [7:0]  color_index;
    } t_result;

    // Fill status of the output queue.
    typedef struct packed {
        logic [1:0] count;
        logic       full;
        logic       empty;
    } t_fifo_stat;

    // Result kinds.
    localparam logic [1:0] C_KIND_PIXEL = 2'd0;
    localparam logic [1:0] C_KIND_DONE  = 2'd1;
    localparam logic [1:0] C_KIND_TRUNC = 2'd2;

    // Post list constants.
    localparam logic [7:0]  C_END_MARK = 8'hFF;
    localparam logic [12:0] C_ROW_SAT  = 13'd8191;
    localparam logic [12:0] C_MAX_DIM  = 13'd4096;

    // Register map.
    localparam logic        C_REG_HEIGHT   = 1'b0;
    localparam logic [11:0] C_HEIGHT_RESET = 12'd128;

endpackage

@@ sv/patch_column_post_decoder_unit.sv @@
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: column_index, data_byte; tlast; tuser
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: column, row, color; tuser: kind
// apb       in   psel/penable/pwrite, pready=1  image_height at byte address 0
//
// One word is accepted per cycle while the output queue is not full; it is parsed in the input register,
// and its result is written into the output queue as the word leaves that register.
// The input register and the parser state update set that single-cycle rate.
// A two-word output queue lets input continue while a result waits.
// Reset is synchronous and clears the parser, the queue and image_height to 128.
// A full queue holds the input register, which then drops s_axis_tready.
module patch_column_post_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // column_index[11:0], data_byte[19:12], zero pad
    input  logic        s_axis_tlast,   // lump_end
    input  logic        s_axis_tuser,   // column_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // pixel_column[11:0], pixel_row[23:12], color[31:24]
    output logic [1:0]  m_axis_tuser,   // result_kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pcpd_pkg::*;

    logic        r_in_valid;
    t_item       r_in;
    logic [11:0] r_height;
    logic        w_accept;
    logic        w_fire;
    logic        w_res_valid;
    t_result     w_res;
    t_result     w_out;
    t_fifo_stat  w_fstat;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == C_REG_HEIGHT) ? {20'd0, r_height} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= C_HEIGHT_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == C_REG_HEIGHT)) begin
            r_height <= pwdata[11:0];
        end
    end

    // Input register; it drains whenever the queue has room.
    assign w_fire        = r_in_valid && !w_fstat.full;
    assign s_axis_tready = !r_in_valid || w_fire;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.column_start <= s_axis_tuser;
            r_in.lump_end     <= s_axis_tlast;
            r_in.column_index <= s_axis_tdata[11:0];
            r_in.data_byte    <= s_axis_tdata[19:12];
        end
    end

    pcpd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_item      (r_in),
        .i_height    (r_height),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    pcpd_out_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_fire && w_res_valid),
        .i_wr_data (w_res),
        .i_rd_en   (m_axis_tvalid && m_axis_tready),
        .o_rd_data (w_out),
        .o_stat    (w_fstat)
    );

    // Output stream.
    assign m_axis_tvalid = !w_fstat.empty;
    assign m_axis_tuser  = w_out.result_kind;
    assign m_axis_tdata  = {w_out.color_index, w_out.pixel_row, w_out.pixel_column};

    // Input may stall only while a word sits in the input register.
    a_stall_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid)
        else $error("input stalled with an empty input register");

    // The queue never passes two entries.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fstat.count != 2'd3)
        else $error("output queue overflow");

    // A pushed word always has room in the queue.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_res_valid) |-> !w_fstat.full)
        else $error("result pushed into a full queue");

    // A pixel write is always inside the configured height.
    a_pixel_in_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_res_valid && (w_res.result_kind == C_KIND_PIXEL))
            |-> (w_res.pixel_row < r_height))
        else $error("pixel row beyond image height");

endmodule

@@ sv/pcpd_core.sv @@
module pcpd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  pcpd_pkg::t_item  i_item,
    input  logic [11:0]      i_height,
    output logic             o_res_valid,
    output pcpd_pkg::t_result o_res
);
    import pcpd_pkg::*;

    // Parse phases.
    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_COUNT  = 3'd1;
    localparam logic [2:0] PH_DUMMY  = 3'd2;
    localparam logic [2:0] PH_PIXELS = 3'd3;
    localparam logic [2:0] PH_TRAIL  = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    logic [2:0]  r_phase, n_phase;
    logic [12:0] r_offset, n_offset;
    logic [7:0]  r_left, n_left;
    logic [12:0] r_cursor, n_cursor;
    logic [11:0] r_column, n_column;

    // State as seen by this word, after a column start has cleared it.
    logic [2:0]  w_phase;
    logic [12:0] w_offset;
    logic [12:0] w_cursor;
    logic [7:0]  w_left;
    logic [13:0] w_sum;
    logic [7:0]  w_left_dec;
    logic        w_keep;

    assign w_phase  = i_item.column_start ? PH_START : r_phase;
    assign w_offset = i_item.column_start ? 13'd0 : r_offset;
    assign w_cursor = i_item.column_start ? 13'd0 : r_cursor;
    assign w_left   = i_item.column_start ? 8'd0 : r_left;
    assign n_column = i_item.column_start ? i_item.column_index : r_column;

    assign w_sum      = {1'b0, w_offset} + {6'd0, i_item.data_byte};
    assign w_left_dec = w_left - 8'd1;
    assign w_keep     = (w_cursor < {1'b0, i_height}) && (w_cursor < C_MAX_DIM);

    // One parse step per word.
    always_comb begin
        n_phase  = w_phase;
        n_offset = w_offset;
        n_cursor = w_cursor;
        n_left   = w_left;
        o_res_valid        = 1'b0;
        o_res.result_kind  = C_KIND_PIXEL;
        o_res.pixel_column = n_column;
        o_res.pixel_row    = 12'd0;
        o_res.color_index  = 8'd0;
        if (w_phase != PH_DONE) begin
            if (i_item.lump_end) begin
                n_phase           = PH_DONE;
                o_res_valid       = 1'b1;
                o_res.result_kind = (w_phase == PH_START) ? C_KIND_DONE : C_KIND_TRUNC;
            end else begin
                case (w_phase)
                    PH_START: begin
                        if (i_item.data_byte == C_END_MARK) begin
                            n_phase           = PH_DONE;
                            o_res_valid       = 1'b1;
                            o_res.result_kind = C_KIND_DONE;
                        end else begin
                            // Tall-patch rule: small start rows stack on the offset.
                            if ({5'd0, i_item.data_byte} <= w_offset) begin
                                n_offset = (w_sum > {1'b0, C_ROW_SAT}) ? C_ROW_SAT
                                                                       : w_sum[12:0];
                            end else begin
                                n_offset = {5'd0, i_item.data_byte};
                            end
                            n_cursor = n_offset;
                            n_phase  = PH_COUNT;
                        end
                    end
                    PH_COUNT: begin
                        n_left  = i_item.data_byte;
                        n_phase = PH_DUMMY;
                    end
                    PH_DUMMY: begin
                        n_phase = (w_left != 8'd0) ? PH_PIXELS : PH_TRAIL;
                    end
                    PH_PIXELS: begin
                        if (w_cursor < C_ROW_SAT) begin
                            n_cursor = w_cursor + 13'd1;
                        end
                        n_left = w_left_dec;
                        if (w_left_dec == 8'd0) begin
                            n_phase = PH_TRAIL;
                        end
                        if (w_keep) begin
                            o_res_valid       = 1'b1;
                            o_res.pixel_row   = w_cursor[11:0];
                            o_res.color_index = i_item.data_byte;
                        end
                    end
                    PH_TRAIL: begin
                        n_phase = PH_START;
                    end
                    default: begin
                        n_phase = PH_DONE;
                    end
                endcase
            end
        end
    end

    // Parser state advances only on a processed word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_offset <= 13'd0;
            r_left   <= 8'd0;
            r_cursor <= 13'd0;
            r_column <= 12'd0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_offset <= n_offset;
            r_left   <= n_left;
            r_cursor <= n_cursor;
            r_column <= n_column;
        end
    end

endmodule

@@ sv/pcpd_out_fifo.sv @@
module pcpd_out_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  pcpd_pkg::t_result    i_wr_data,
    input  logic                 i_rd_en,
    output pcpd_pkg::t_result    o_rd_data,
    output pcpd_pkg::t_fifo_stat o_stat
);
    import pcpd_pkg::*;

    t_result    r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count, n_count;

    assign o_rd_data    = r_mem[r_rptr];
    assign o_stat.count = r_count;
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

    // Count moves by the difference of pushes and pops.
    always_comb begin
        n_count = r_count;
        if (i_wr_en && !i_rd_en) begin
            n_count = r_count + 2'd1;
        end else if (!i_wr_en && i_rd_en) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_wr_en) begin
                r_wptr <= ~r_wptr;
            end
            if (i_rd_en) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    // Storage holds payload only.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

endmodule
